/* hw/rtl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the house clock and reset names.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* hw/rtl/bole_pkg.sv */
// Types, codes and defaults shared by the ordered list engine.
package bole_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_REMOVE    = 3'd2;
  localparam logic [2:0] CMD_SEARCH    = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [2:0] {
    OP_INS_FRONT,
    OP_INS_BACK,
    OP_REMOVE,
    OP_SEARCH,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } bole_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] count;
    logic       empty_res;
  } bole_out_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] value;
  } bole_qitem_t;

endpackage

/* hw/rtl/bole_front.sv */
// Command front end: accepts commands, decodes them and queues them for the back end.
module bole_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  bole_pkg::bole_in_t   req_i,
  output logic                 q_valid_o,
  output bole_pkg::bole_qitem_t q_item_o,
  input  logic                 pop_i
);
  import bole_pkg::*;

  bole_qitem_t slot_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  fill_q, fill_d;
  logic        push, pop;
  bole_qitem_t item;

  always_comb begin
    item.value = req_i.value;
    unique case (req_i.cmd)
      CMD_INS_FRONT: item.op = OP_INS_FRONT;
      CMD_INS_BACK:  item.op = OP_INS_BACK;
      CMD_REMOVE:    item.op = OP_REMOVE;
      CMD_SEARCH:    item.op = OP_SEARCH;
      CMD_CLEAR:     item.op = OP_CLEAR;
      default:       item.op = OP_NOP;
    endcase
  end

  assign busy_o    = (fill_q == 2'd2);
  assign q_valid_o = (fill_q != 2'd0);
  assign q_item_o  = slot_q[rd_q];
  assign push      = start_i && !busy_o;
  assign pop       = pop_i && q_valid_o;

  always_comb begin
    wr_d   = push ? ~wr_q : wr_q;
    rd_d   = pop ? ~rd_q : rd_q;
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item;
    end
  end

endmodule

/* hw/rtl/bole_back.sv */
// Command back end: the list cells, the match scan and the result register.
module bole_back #(
  parameter int unsigned CAPACITY = bole_pkg::DEFAULT_CAPACITY
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  bole_pkg::bole_qitem_t q_item_i,
  output logic                  pop_o,
  output logic                  done_o,
  output bole_pkg::bole_out_t   res_o
);
  import bole_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [CAPACITY-1:0] match_q, match_d, hits;
  op_e             op_q, op_d;
  logic            done_q, done_d;
  bole_out_t       res_q, res_d;
  logic [31:0]     cells_q [CAPACITY];
  logic [31:0]     cells_d [CAPACITY];
  logic            full;
  logic            do_front, do_back, do_remove;

  assign full   = (count_q == CW'(CAPACITY));
  assign pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign done_o = done_q;
  assign res_o  = res_q;

  // Every cell compares against the command value at once.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      hits[k] = (CW'(k) < count_q) && (cells_q[k] == q_item_i.value);
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    match_d   = match_q;
    op_d      = op_q;
    done_d    = 1'b0;
    res_d     = res_q;
    do_front  = 1'b0;
    do_back   = 1'b0;
    do_remove = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          res_d.status   = ST_OK;
          res_d.position = 4'd0;
          unique case (q_item_i.op)
            OP_INS_FRONT, OP_INS_BACK: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                count_d  = count_q + 1'b1;
                do_front = (q_item_i.op == OP_INS_FRONT);
                do_back  = (q_item_i.op == OP_INS_BACK);
              end
              done_d = 1'b1;
            end
            OP_REMOVE, OP_SEARCH: begin
              match_d = hits;
              pos_d   = '0;
              op_d    = q_item_i.op;
              state_d = S_SCAN;
            end
            OP_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // The match vector moves down one place a cycle until its lowest bit is set; an empty vector gives not found.
        if (match_q == '0) begin
          res_d.status   = ST_NOTFOUND;
          res_d.position = 4'd0;
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else if (match_q[0]) begin
          res_d.status   = ST_OK;
          res_d.position = 4'(pos_q);
          done_d         = 1'b1;
          state_d        = S_IDLE;
          if (op_q == OP_REMOVE) begin
            count_d   = count_q - 1'b1;
            do_remove = 1'b1;
          end
        end else begin
          match_d = match_q >> 1;
          pos_d   = pos_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res_d.count     = 5'(count_d);
    res_d.empty_res = (count_d == '0);
  end

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cells_d[k] = cells_q[k];
    end
    if (do_front) begin
      cells_d[0] = q_item_i.value;
      for (int k = 1; k < CAPACITY; k++) begin
        cells_d[k] = cells_q[k-1];
      end
    end
    if (do_back) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (CW'(k) == count_q) begin
          cells_d[k] = q_item_i.value;
        end
      end
    end
    if (do_remove) begin
      for (int k = 0; k < CAPACITY - 1; k++) begin
        if (PW'(k) >= pos_q) begin
          cells_d[k] = cells_q[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pos_q   <= '0;
      match_q <= '0;
      op_q    <= OP_NOP;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      match_q <= match_d;
      op_q    <= op_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CAPACITY; k++) begin
      cells_q[k] <= cells_d[k];
    end
  end

endmodule

/* hw/rtl/bounded_ordered_list_engine.sv */
// Top level of the bounded ordered list engine.
//
// Commands enter on req_i (cmd, value) and transfer at a clock edge where start
// is high and busy is low. A two-entry command queue sits in front of the list
// back end, so busy rises only when that queue is full.
// Every command gives exactly one result on res_o (status, position, count,
// empty_res), shown for a single cycle with done_o high; the receiver has no
// way to hold it off and must take it in that cycle.
// Inserts, clear and unused codes pass the queue slot and the result register;
// search and remove also load the match vector and scan it up to the matched
// position, or end the scan on an empty match vector. The back end handles one
// command at a time, and the scan of the match vector, one position a cycle,
// sets the time of search and remove. Results come out in command order.
// Reset empties the list and the queue; list contents are not cleared.
module bounded_ordered_list_engine #(
  parameter int unsigned CAPACITY = bole_pkg::DEFAULT_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bole_pkg::bole_in_t  req_i,
  output logic                done_o,
  output bole_pkg::bole_out_t res_o
);
  import bole_pkg::*;

  logic        q_valid;
  logic        pop;
  bole_qitem_t q_item;

  bole_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .pop_i     (pop)
  );

  bole_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .done_o    (done_o),
    .res_o     (res_o)
  );

endmodule

/* hw/rtl/bole_chk.sv */
// Port-level checker for the ordered list engine, bound to the top level.
`include "assert_macros.svh"

module bole_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                done_o,
  input bole_pkg::bole_out_t res_o
);
  import bole_pkg::*;

  // Commands transferred whose results have not yet been shown.
  logic [2:0] open_q;
  logic       acc;

  assign acc = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 3'd0;
    end else begin
      open_q <= open_q + {2'b0, acc} - {2'b0, done_o};
    end
  end

  `ASSERT_DEF(a_no_extra_result, done_o |-> (open_q != 3'd0),
              "result without a pending command")
  `ASSERT_DEF(a_busy_only_loaded, busy |-> (open_q >= 3'd2),
              "busy while the queue has room")
  `ASSERT_DEF(a_empty_flag,
              done_o |-> (res_o.empty_res == (res_o.count == 5'd0)),
              "empty flag disagrees with count")
  `ASSERT_DEF(a_pos_on_fail,
              (done_o && (res_o.status != ST_OK)) |-> (res_o.position == 4'd0),
              "position set on a failed command")
  `ASSERT_DEF(a_status_code,
              done_o |-> ((res_o.status == ST_OK) || (res_o.status == ST_FULL) ||
                          (res_o.status == ST_NOTFOUND)),
              "undefined status code")

endmodule

bind bounded_ordered_list_engine bole_chk u_bole_chk (.*);
